// ----- src/psd_pkg.sv -----
// psd_pkg: shared types, command codes and constants of the plot stream decoder.
// No dependencies.
package psd_pkg;

  // Command letters
  localparam logic [7:0] CH_MOVE   = 8'h6d;  // m
  localparam logic [7:0] CH_CONT   = 8'h6e;  // n
  localparam logic [7:0] CH_POINT  = 8'h70;  // p
  localparam logic [7:0] CH_LINE   = 8'h6c;  // l
  localparam logic [7:0] CH_LABEL  = 8'h74;  // t
  localparam logic [7:0] CH_ARC    = 8'h61;  // a
  localparam logic [7:0] CH_CIRCLE = 8'h63;  // c
  localparam logic [7:0] CH_ERASE  = 8'h65;  // e
  localparam logic [7:0] CH_STYLE  = 8'h66;  // f
  localparam logic [7:0] CH_SPACE  = 8'h73;  // s
  localparam logic [7:0] CH_NL     = 8'h0a;

  // Completion codes handed to the datapath (coordinate ones match the parse codes)
  localparam logic [3:0] PC_MOVE    = 4'd0;
  localparam logic [3:0] PC_CONT    = 4'd1;
  localparam logic [3:0] PC_POINT   = 4'd2;
  localparam logic [3:0] PC_LINE    = 4'd3;
  localparam logic [3:0] PC_LCHAR   = 4'd4;
  localparam logic [3:0] PC_ARC     = 4'd5;
  localparam logic [3:0] PC_CIRCLE  = 4'd6;
  localparam logic [3:0] PC_STYLE   = 4'd7;
  localparam logic [3:0] PC_SPACE   = 4'd8;
  localparam logic [3:0] PC_ERASE   = 4'd9;
  localparam logic [3:0] PC_UNKNOWN = 4'd10;
  localparam logic [3:0] PC_LEND    = 4'd11;

  // Result kinds
  localparam logic [3:0] K_LINE    = 4'd0;
  localparam logic [3:0] K_POINT   = 4'd1;
  localparam logic [3:0] K_CIRCLE  = 4'd2;
  localparam logic [3:0] K_ARC     = 4'd3;
  localparam logic [3:0] K_ERASE   = 4'd4;
  localparam logic [3:0] K_LCHAR   = 4'd5;
  localparam logic [3:0] K_LEND    = 4'd6;
  localparam logic [3:0] K_STYLE   = 4'd7;
  localparam logic [3:0] K_UNKNOWN = 4'd8;

  // Per-byte actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_LO    = 3'd1;
  localparam logic [2:0] ACT_HI    = 3'd2;
  localparam logic [2:0] ACT_NCLR  = 3'd3;
  localparam logic [2:0] ACT_NBYTE = 3'd4;

  // Line styles
  localparam logic [1:0] ST_SOLID  = 2'd0;
  localparam logic [1:0] ST_ONOFF  = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;

  // Style names
  localparam int NUM_NAMES = 5;
  localparam logic [2:0] NM_SOLID  = 3'd0;
  localparam logic [2:0] NM_DOTTED = 3'd1;
  localparam logic [2:0] NM_SHORT  = 3'd2;
  localparam logic [2:0] NM_LONG   = 3'd3;
  localparam logic [2:0] NM_DOTDSH = 3'd4;

  localparam int CFG_W = 13;
  localparam int OUT_W = 208;

  typedef struct packed {
    logic       take;       // input beat accepted
    logic [2:0] act;
    logic [2:0] idx;        // coordinate slot for ACT_HI
    logic       prep;       // command complete, set up result
    logic [3:0] pcode;
    logic       map_start;
    logic [2:0] slot;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] nslots;
    logic       map_done;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [3:0] name_len(input logic [2:0] k);
    case (k)
      NM_SOLID:  name_len = 4'd5;
      NM_DOTTED: name_len = 4'd6;
      NM_SHORT:  name_len = 4'd11;
      NM_LONG:   name_len = 4'd10;
      NM_DOTDSH: name_len = 4'd9;
      default:   name_len = 4'd0;
    endcase
  endfunction

  // Character i of style name k (names left aligned, space padded to 11)
  function automatic logic [7:0] name_char(input logic [2:0] k, input logic [3:0] i);
    logic [87:0] s;
    case (k)
      NM_SOLID:  s = "solid      ";
      NM_DOTTED: s = "dotted     ";
      NM_SHORT:  s = "shortdashed";
      NM_LONG:   s = "longdashed ";
      NM_DOTDSH: s = "dotdashed  ";
      default:   s = '0;
    endcase
    if (i > 4'd10) name_char = 8'h00;
    else name_char = s[8*(4'd10 - i) +: 8];
  endfunction

  function automatic logic [3:0] coord_count(input logic [3:0] c);
    case (c)
      PC_LINE, PC_SPACE: coord_count = 4'd4;
      PC_ARC:            coord_count = 4'd6;
      PC_CIRCLE:         coord_count = 4'd3;
      default:           coord_count = 4'd2;
    endcase
  endfunction

endpackage

// ----- src/plot_stream_decoder.sv -----
// plot_stream_decoder: top level of the plot command byte stream decoder.
// Instantiates psd_ctrl and psd_dp; uses psd_pkg.
//
// Input channel in_*: one command-stream byte per beat. Output channel out_*:
// one draw primitive per beat, kind on out_tuser. cfg_* writes the screen
// width (index 0) or height (index 1); the user must use it only while the
// block is idle, which the block itself does not enforce. A byte that
// completes nothing is taken while the block stays idle. A byte that
// completes a command with no mapping (erase, style, unknown) passes the
// setup, check and output states before its result is registered. Each
// mapped coordinate goes in turn through the shared mapping unit (issue with
// the multiply, serial divide, hand back): a label byte maps two, a line or circle four, an arc six.
// in_tready is low while a completed command is being set up and mapped; a
// finished result sits in the output register and further bytes that produce
// no result are taken while it waits. If the receiver stalls, the next
// result waits in the sequencer and input stays blocked until the register frees.
// Reset (synchronous, rst_n low) returns to waiting for a command letter,
// clears the window, the current point and the style, and sets both screen
// sizes to 500.
module plot_stream_decoder import psd_pkg::*; #(
  parameter int NAME_MAX = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // in_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  // x_a, y_a, x_b, y_b, x_c, y_c, text_byte, style, zero_span, zero pad
  output logic [OUT_W-1:0] out_tdata,
  output logic [3:0]       out_tuser,   // kind
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  psd_dp #(.NAME_MAX(NAME_MAX)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser)
  );
endmodule

// ----- src/psd_map.sv -----
// psd_map: maps one coordinate to pixels, trunc(num*mul/span).
// A multiply step, then a restoring divider retiring one quotient bit a cycle. Uses psd_pkg.
module psd_map import psd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] num,
  input  logic [CFG_W-1:0]   mul,
  input  logic signed [17:0] span,
  output logic               done,
  output logic [31:0]        quo,
  output logic               zf
);
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [29:0] dvd_r, dvd_nxt;
  logic [16:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic        neg_r, neg_nxt, zf_r, zf_nxt;
  logic [16:0] num_mag;
  logic [17:0] span_mag, trial;
  logic [31:0] q32;

  assign num_mag  = num[16] ? 17'(-num) : 17'(num);
  assign span_mag = span[17] ? 18'(-span) : 18'(span);
  assign trial    = {rem_r, dvd_r[29]};

  // Control and divide step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    zf_nxt   = zf_r;
    if (start) begin
      neg_nxt = num[16] ^ span[17];
      rem_nxt = '0;
      dsr_nxt = span_mag[16:0];
      cnt_nxt = 5'd29;
      if (span == '0) begin
        zf_nxt   = 1'b1;
        dvd_nxt  = '0;
        done_nxt = 1'b1;
      end else begin
        zf_nxt   = 1'b0;
        dvd_nxt  = 30'(num_mag * mul);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 17'(trial - {1'b0, dsr_r});
        dvd_nxt = {dvd_r[28:0], 1'b1};
      end else begin
        rem_nxt = trial[16:0];
        dvd_nxt = {dvd_r[28:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
    zf_r  <= zf_nxt;
  end

  assign q32  = {2'b00, dvd_r};
  assign quo  = neg_r ? 32'(-q32) : q32;
  assign done = done_r;
  assign zf   = zf_r;
endmodule

// ----- src/psd_dp.sv -----
// psd_dp: datapath: coordinate store, plot state, style name matcher, mapping unit, output register.
// Driven by psd_ctrl through dp_cmd_t. Uses psd_pkg and psd_map.
module psd_dp import psd_pkg::*; #(
  parameter int NAME_MAX = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic [7:0]       in_byte,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic [3:0]       out_kind
);
  localparam int LW = $clog2(NAME_MAX + 2);

  logic [CFG_W-1:0]   width_r, height_r;
  logic [7:0]         lo_r, byte_r, text_r;
  logic signed [15:0] c_r [6];
  logic signed [15:0] cur_x_r, cur_y_r, xmin_r, ymax_r;
  logic signed [17:0] span_x_r, span_y_r;
  logic               win_r;
  logic [1:0]         style_r;
  logic [LW-1:0]      nlen_r;
  logic [NUM_NAMES-1:0] match_r;
  logic signed [16:0] ops_r [6];
  logic [31:0]        v_r [6];
  logic               zf_r, emit_r;
  logic [2:0]         nslots_r;
  logic [3:0]         kind_r;
  logic               ovalid_r;
  logic [OUT_W-1:0]   odata_r;
  logic [3:0]         okind_r;
  logic               map_done, map_zf;
  logic [31:0]        map_quo;

  function automatic logic signed [16:0] dx(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
    dx = 17'({a[15], a} - {b[15], b});
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(500);
      height_r <= CFG_W'(500);
    end else if (cfg_we) begin
      if (cfg_addr) height_r <= cfg_wdata;
      else width_r <= cfg_wdata;
    end
  end

  // Per-beat capture: coordinate bytes and style name matching
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r    <= '0;
      nlen_r  <= '0;
      match_r <= '0;
    end else if (cmd.take) begin
      case (cmd.act)
        ACT_LO:   lo_r <= in_byte;
        ACT_NCLR: begin
          nlen_r  <= '0;
          match_r <= '1;
        end
        ACT_NBYTE: begin
          if (nlen_r < LW'(NAME_MAX)) begin
            for (int k = 0; k < NUM_NAMES; k++) begin
              match_r[k] <= match_r[k] && ({{(LW-4){1'b0}}, name_len(3'(k))} > nlen_r)
                            && (in_byte == name_char(3'(k), nlen_r[3:0]));
            end
            nlen_r <= nlen_r + LW'(1);
          end else begin
            nlen_r  <= LW'(NAME_MAX + 1);
            match_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_byte;
      if (cmd.act == ACT_HI) c_r[cmd.idx] <= {in_byte, lo_r};
    end
  end

  // Command setup: plot state update, result kind and number of mapped slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      xmin_r   <= '0;
      ymax_r   <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      win_r    <= 1'b0;
      style_r  <= ST_SOLID;
      emit_r   <= 1'b0;
      nslots_r <= '0;
      kind_r   <= K_LINE;
      zf_r     <= 1'b0;
    end else if (cmd.prep) begin
      emit_r   <= 1'b0;
      nslots_r <= 3'd0;
      zf_r     <= 1'b0;
      case (cmd.pcode)
        PC_MOVE: begin
          cur_x_r <= c_r[0];
          cur_y_r <= c_r[1];
        end
        PC_CONT: begin
          cur_x_r  <= c_r[0];
          cur_y_r  <= c_r[1];
          emit_r   <= win_r;
          nslots_r <= 3'd4;
          kind_r   <= K_LINE;
        end
        PC_POINT: begin
          cur_x_r  <= c_r[0];
          cur_y_r  <= c_r[1];
          emit_r   <= win_r;
          nslots_r <= 3'd2;
          kind_r   <= K_POINT;
        end
        PC_LINE: begin
          cur_x_r  <= c_r[2];
          cur_y_r  <= c_r[3];
          emit_r   <= win_r;
          nslots_r <= 3'd4;
          kind_r   <= K_LINE;
        end
        PC_ARC: begin
          emit_r   <= win_r;
          nslots_r <= 3'd6;
          kind_r   <= K_ARC;
        end
        PC_CIRCLE: begin
          emit_r   <= win_r;
          nslots_r <= 3'd4;
          kind_r   <= K_CIRCLE;
        end
        PC_LCHAR, PC_LEND: begin
          emit_r   <= 1'b1;
          nslots_r <= 3'd2;
          kind_r   <= (cmd.pcode == PC_LEND) ? K_LEND : K_LCHAR;
        end
        PC_STYLE: begin
          emit_r <= 1'b1;
          kind_r <= K_STYLE;
          if (match_r[NM_SOLID] && nlen_r == LW'(5)) style_r <= ST_SOLID;
          else if ((match_r[NM_DOTTED] && nlen_r == LW'(6)) ||
                   (match_r[NM_SHORT] && nlen_r == LW'(11))) style_r <= ST_ONOFF;
          else if ((match_r[NM_LONG] && nlen_r == LW'(10)) ||
                   (match_r[NM_DOTDSH] && nlen_r == LW'(9))) style_r <= ST_DOUBLE;
        end
        PC_SPACE: begin
          win_r    <= 1'b1;
          xmin_r   <= c_r[0];
          ymax_r   <= c_r[3];
          span_x_r <= 18'({{2{c_r[2][15]}}, c_r[2]} + 18'sd1 - {{2{c_r[0][15]}}, c_r[0]});
          span_y_r <= 18'({{2{c_r[3][15]}}, c_r[3]} + 18'sd1 - {{2{c_r[1][15]}}, c_r[1]});
        end
        PC_ERASE: begin
          emit_r <= 1'b1;
          kind_r <= K_ERASE;
        end
        PC_UNKNOWN: begin
          emit_r <= 1'b1;
          kind_r <= K_UNKNOWN;
        end
        default: ;
      endcase
    end else if (map_done) begin
      zf_r <= zf_r | map_zf;
    end
  end

  // Operands, text and result slots
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      text_r <= (cmd.pcode == PC_LCHAR || cmd.pcode == PC_UNKNOWN) ? byte_r : 8'h00;
      for (int i = 0; i < 6; i++) v_r[i] <= '0;
      ops_r[4] <= dx(c_r[4], xmin_r);
      ops_r[5] <= dx(ymax_r, c_r[5]);
      case (cmd.pcode)
        PC_CONT: begin
          ops_r[0] <= dx(cur_x_r, xmin_r);
          ops_r[1] <= dx(ymax_r, cur_y_r);
          ops_r[2] <= dx(c_r[0], xmin_r);
          ops_r[3] <= dx(ymax_r, c_r[1]);
        end
        PC_LCHAR, PC_LEND: begin
          ops_r[0] <= dx(cur_x_r, xmin_r);
          ops_r[1] <= dx(ymax_r, cur_y_r);
          ops_r[2] <= '0;
          ops_r[3] <= '0;
        end
        PC_CIRCLE: begin
          ops_r[0] <= dx(c_r[0], xmin_r);
          ops_r[1] <= dx(ymax_r, c_r[1]);
          ops_r[2] <= 17'(c_r[2]);
          ops_r[3] <= 17'(c_r[2]);
        end
        default: begin
          ops_r[0] <= dx(c_r[0], xmin_r);
          ops_r[1] <= dx(ymax_r, c_r[1]);
          ops_r[2] <= dx(c_r[2], xmin_r);
          ops_r[3] <= dx(ymax_r, c_r[3]);
        end
      endcase
    end else if (map_done) begin
      v_r[cmd.slot] <= map_quo;
    end
  end

  // Mapping unit: odd slots are y
  psd_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.map_start),
    .num   (ops_r[cmd.slot]),
    .mul   (cmd.slot[0] ? height_r : width_r),
    .span  (cmd.slot[0] ? span_y_r : span_x_r),
    .done  (map_done),
    .quo   (map_quo),
    .zf    (map_zf)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (out_ready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= {5'b0, zf_r, style_r, text_r, v_r[5], v_r[4], v_r[3], v_r[2], v_r[1], v_r[0]};
      okind_r <= kind_r;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_data      = odata_r;
  assign out_kind      = okind_r;
  assign stat.emit     = emit_r;
  assign stat.nslots   = nslots_r;
  assign stat.map_done = map_done;
  assign stat.out_free = !ovalid_r || out_ready;
endmodule

// ----- src/psd_ctrl.sv -----
// psd_ctrl: byte parser and result sequencer of the plot stream decoder.
// Issues dp_cmd_t to psd_dp and reads dp_stat_t back. Uses psd_pkg.
module psd_ctrl import psd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MAP  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] PH_LETTER = 2'd0;
  localparam logic [1:0] PH_COORD  = 2'd1;
  localparam logic [1:0] PH_TEXT   = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] pend_r, pend_nxt, pcode_r, pcode_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic       take;
  logic [3:0] ncoord;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;
  assign ncoord   = coord_count(pend_r);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    pcode_nxt = pcode_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    cmd       = '0;
    cmd.take  = take;
    cmd.idx   = cnt_r[3:1];
    cmd.pcode = pcode_r;
    cmd.slot  = slot_r;
    case (state_r)
      // Parse one beat
      S_IDLE: begin
        if (take) begin
          case (phase_r)
            PH_LETTER: begin
              cnt_nxt = '0;
              case (in_byte)
                CH_ERASE: begin pcode_nxt = PC_ERASE; state_nxt = S_PREP; end
                CH_LABEL: begin pend_nxt = PC_LCHAR; phase_nxt = PH_TEXT; end
                CH_STYLE: begin
                  pend_nxt  = PC_STYLE;
                  phase_nxt = PH_TEXT;
                  cmd.act   = ACT_NCLR;
                end
                CH_MOVE:   begin pend_nxt = PC_MOVE;   phase_nxt = PH_COORD; end
                CH_CONT:   begin pend_nxt = PC_CONT;   phase_nxt = PH_COORD; end
                CH_POINT:  begin pend_nxt = PC_POINT;  phase_nxt = PH_COORD; end
                CH_LINE:   begin pend_nxt = PC_LINE;   phase_nxt = PH_COORD; end
                CH_ARC:    begin pend_nxt = PC_ARC;    phase_nxt = PH_COORD; end
                CH_CIRCLE: begin pend_nxt = PC_CIRCLE; phase_nxt = PH_COORD; end
                CH_SPACE:  begin pend_nxt = PC_SPACE;  phase_nxt = PH_COORD; end
                default:   begin pcode_nxt = PC_UNKNOWN; state_nxt = S_PREP; end
              endcase
            end
            PH_TEXT: begin
              if (pend_r == PC_LCHAR) begin
                state_nxt = S_PREP;
                if (in_byte == CH_NL) begin
                  pcode_nxt = PC_LEND;
                  phase_nxt = PH_LETTER;
                end else begin
                  pcode_nxt = PC_LCHAR;
                end
              end else if (in_byte == CH_NL) begin
                pcode_nxt = PC_STYLE;
                phase_nxt = PH_LETTER;
                state_nxt = S_PREP;
              end else begin
                cmd.act = ACT_NBYTE;
              end
            end
            default: begin
              cmd.act = cnt_r[0] ? ACT_HI : ACT_LO;
              cnt_nxt = cnt_r + 4'd1;
              if (cnt_nxt == {ncoord[2:0], 1'b0}) begin
                cnt_nxt   = '0;
                phase_nxt = PH_LETTER;
                pcode_nxt = pend_r;
                state_nxt = S_PREP;
              end
            end
          endcase
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        slot_nxt = '0;
        if (!stat.emit) state_nxt = S_IDLE;
        else if (stat.nslots == 3'd0) state_nxt = S_OUT;
        else state_nxt = S_MAP;
      end
      S_MAP: begin
        cmd.map_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (stat.map_done) begin
          if (slot_r + 3'd1 == stat.nslots) begin
            state_nxt = S_OUT;
          end else begin
            slot_nxt  = slot_r + 3'd1;
            state_nxt = S_MAP;
          end
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_LETTER;
      pend_r  <= PC_MOVE;
      pcode_r <= PC_MOVE;
      cnt_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      pcode_r <= pcode_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
    end
  end
endmodule

// ----- src/psd_checker.sv -----
// psd_checker: port-level checks of plot_stream_decoder, bound to the top level.
// Uses psd_pkg.
module psd_checker import psd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [3:0]       out_tuser
);
  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // Kind and style codes stay in range
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= K_UNKNOWN && out_tdata[201:200] <= ST_DOUBLE)
    else $error("kind or style out of range");

  // Unmapped kinds carry no coordinates and no zero-span flag
  a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == K_ERASE || out_tuser == K_STYLE || out_tuser == K_UNKNOWN)
    |-> out_tdata[191:0] == '0 && !out_tdata[202])
    else $error("unmapped kind carries coordinates");

  // Label end carries no character; only arcs use the third point
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != K_LEND || out_tdata[199:192] == 8'h00)
                && (out_tuser == K_ARC || out_tdata[191:128] == '0))
    else $error("unused field not zero");
endmodule

bind plot_stream_decoder psd_checker u_psd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
